### hdl/erlv_pkg.sv
package erlv_pkg;

   typedef enum logic [2:0] {
      V_PENDING = 3'd0,
      V_RECORD  = 3'd1,
      V_REJECT  = 3'd2,
      V_VALID   = 3'd3,
      V_EMPTY   = 3'd4
   } verdict_type;

   typedef enum logic [1:0] {
      GO_ON,
      GO_NEXT,
      GO_BAD,
      GO_LINE
   } step_type;

   localparam logic [3:0] F_STAMP  = 4'd0;
   localparam logic [3:0] F_SEQ    = 4'd1;
   localparam logic [3:0] F_NAME   = 4'd2;
   localparam logic [3:0] F_CLASS  = 4'd3;
   localparam logic [3:0] F_DIGEST = 4'd4;
   localparam logic [3:0] F_CODE   = 4'd5;
   localparam logic [3:0] F_DUR0   = 4'd6;
   localparam logic [3:0] F_DUR1   = 4'd7;
   localparam logic [3:0] F_DUR2   = 4'd8;

   localparam logic [1:0] CSR_NAME_MAX   = 2'd0;
   localparam logic [1:0] CSR_ALGO_MAX   = 2'd1;
   localparam logic [1:0] CSR_DIGEST_MAX = 2'd2;

   localparam logic [5:0] TS_FRACTION = 6'd20;
   localparam logic [5:0] TS_ZONE     = 6'd21;
   localparam logic [5:0] TS_COLON    = 6'd23;
   localparam logic [5:0] TS_TAB      = 6'd26;
   localparam logic [5:0] DIGEST_PART = 6'd63;

   localparam logic [7:0] NUM_DIGITS_MAX  = 8'd21;
   localparam logic [7:0] SEC_DIGITS_MAX  = 8'd10;
   localparam logic [7:0] FRAC_DIGITS_MAX = 8'd9;

   localparam logic [63:0] SEC_MAX   = 64'd2147483647;
   localparam logic [63:0] SEQ_LIMIT = 64'd922337203685477580;

   localparam logic [7:0] TAB_CHAR = 8'h09;
   localparam logic [7:0] NL_CHAR  = 8'h0a;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
      logic       nul;
      logic       digit;
      logic       lower;
      logic       upper;
      logic       graph;
      logic       tab;
      logic       nl;
      logic [3:0] digit_val;
   } item_type;

   function automatic logic [7:0] ts_lo(input logic [4:0] p);
      logic [7:0] r;
      case (p)
         5'd4, 5'd7: r = "-";
         5'd10:      r = "T";
         5'd13, 5'd16: r = ":";
         5'd19:      r = ".";
         5'd0:       r = "2";
         default:    r = "0";
      endcase
      return r;
   endfunction

   function automatic logic [7:0] ts_hi(input logic [4:0] p);
      logic [7:0] r;
      case (p)
         5'd4, 5'd7: r = "-";
         5'd10:      r = "T";
         5'd13, 5'd16: r = ":";
         5'd19:      r = ".";
         5'd0:       r = "5";
         5'd5:       r = "1";
         5'd8:       r = "3";
         5'd11:      r = "2";
         5'd14, 5'd17: r = "5";
         default:    r = "9";
      endcase
      return r;
   endfunction

   // class words: ERR, NOPS, OK, SIG
   function automatic logic [7:0] class_char(input logic [1:0] k, input logic [5:0] p);
      logic [7:0] r;
      r = 8'h00;
      case (k)
         2'd0: r = (p == 6'd1) ? "R" : "R";
         2'd1: r = (p == 6'd1) ? "O" : ((p == 6'd2) ? "P" : "S");
         2'd2: r = "K";
         default: r = (p == 6'd1) ? "I" : "G";
      endcase
      return r;
   endfunction

   function automatic logic [5:0] class_len(input logic [1:0] k);
      logic [5:0] r;
      case (k)
         2'd1:    r = 6'd4;
         2'd2:    r = 6'd2;
         default: r = 6'd3;
      endcase
      return r;
   endfunction

endpackage

### hdl/erlv_if.sv
interface erlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;
   modport source (output valid, data_byte, stream_end, input ready);
   modport sink (input valid, data_byte, stream_end, output ready);
endinterface

interface erlv_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] verdict;
   logic [3:0] field_number;
   modport source (output valid, verdict, field_number, input ready);
   modport sink (input valid, verdict, field_number, output ready);
endinterface

interface erlv_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/exec_record_log_validator_core.sv
// path: a byte passes the queue, then the back end scans it into the result register
// throughput: one byte per cycle from the back end scanner, unless the output stalls
// reset: synchronous, active high; clears scan state, empties the queue and output
// register, and loads the limits with 63, 8 and 128
module exec_record_log_validator_core (
   input  logic       clock,
   input  logic       reset,
   erlv_req_if.sink   req_ch,
   erlv_rsp_if.source rsp_ch,
   erlv_csr_if.sink   csr_ch
);
   import erlv_pkg::*;

   item_type cls_item;   // classified byte from the front end
   item_type head_item;  // oldest queued byte
   logic     q_full;
   logic     q_avail;
   logic     q_pop;

   // front end: classify the byte, transfer it into the queue whenever there is room
   assign req_ch.ready = !q_full;

   // limits are always writable
   assign csr_ch.ready = 1'b1;

   erlv_front u_front (
      .data_byte  (req_ch.data_byte),
      .stream_end (req_ch.stream_end),
      .item       (cls_item)
   );

   // short queue so the front keeps taking bytes while the result side stalls
   erlv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_ch.valid && !q_full),
      .push_item (cls_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_avail),
      .head_item (head_item)
   );

   // back end: scanner state machine plus registered result
   erlv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (q_avail),
      .item        (head_item),
      .item_pop    (q_pop),
      .csr_write   (csr_ch.valid),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_verdict (rsp_ch.verdict),
      .out_field   (rsp_ch.field_number)
   );

endmodule

### hdl/erlv_front.sv
module erlv_front (
   input  logic [7:0]       data_byte,
   input  logic             stream_end,
   output erlv_pkg::item_type item
);
   import erlv_pkg::*;

   // character classes used by the scanner
   always_comb begin
      item.data_byte  = data_byte;
      item.stream_end = stream_end;
      item.nul        = (data_byte == 8'h00);
      item.digit      = (data_byte >= "0") && (data_byte <= "9");
      item.lower      = (data_byte >= "a") && (data_byte <= "z");
      item.upper      = (data_byte >= "A") && (data_byte <= "Z");
      item.graph      = (data_byte >= 8'h21) && (data_byte <= 8'h7e);
      item.tab        = (data_byte == TAB_CHAR);
      item.nl         = (data_byte == NL_CHAR);
      item.digit_val  = data_byte[3:0];
   end

endmodule

### hdl/erlv_fifo.sv
module erlv_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  erlv_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output erlv_pkg::item_type head_item
);
   import erlv_pkg::*;

   item_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]       cnt_ff, cnt_in;

   assign full      = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_item = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

### hdl/erlv_back.sv
module erlv_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  erlv_pkg::item_type item,
   output logic              item_pop,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        out_verdict,
   output logic [3:0]        out_field
);
   import erlv_pkg::*;

   logic [5:0]  name_max_ff;
   logic [3:0]  algo_max_ff;
   logic [7:0]  digest_max_ff;

   logic [3:0]  field_ff, field_in;
   logic [5:0]  pos_ff, pos_in;
   logic [7:0]  run_ff, run_in;
   logic [63:0] num_ff, num_in;
   logic        ovf_ff, ovf_in;
   logic        seen_ff, seen_in;
   logic        rej_ff, rej_in;

   logic        oval_ff, oval_in;
   verdict_type verd_ff, verd_in;
   logic [3:0]  ofld_ff, ofld_in;

   step_type    go;
   logic [7:0]  c;
   logic [63:0] num_x10;
   logic [63:0] dig;
   logic [1:0]  k;

   assign item_pop    = item_valid && (!oval_ff || out_ready);
   assign out_valid   = oval_ff;
   assign out_verdict = verd_ff;
   assign out_field   = ofld_ff;

   always_comb begin
      c        = item.data_byte;
      dig      = {60'd0, item.digit_val};
      num_x10  = (num_ff << 3) + (num_ff << 1) + dig;
      k        = run_ff[1:0];
      go       = GO_ON;
      field_in = field_ff;
      pos_in   = pos_ff;
      run_in   = run_ff;
      num_in   = num_ff;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      rej_in   = rej_ff;
      verd_in  = V_PENDING;
      ofld_in  = field_ff;
      oval_in  = oval_ff && !out_ready;

      if (item.stream_end) begin
         if (!seen_ff) begin
            verd_in = V_EMPTY;
            ofld_in = F_STAMP;
         end else if (rej_ff || field_ff != F_STAMP || pos_ff != '0) begin
            verd_in = V_REJECT;
         end else begin
            verd_in = V_VALID;
            ofld_in = F_STAMP;
         end
         field_in = F_STAMP;
         pos_in   = '0;
         run_in   = '0;
         num_in   = '0;
         ovf_in   = 1'b0;
         seen_in  = 1'b0;
         rej_in   = 1'b0;
      end else if (rej_ff || item.nul) begin
         verd_in = rej_ff ? V_REJECT : V_PENDING;
      end else begin
         seen_in = 1'b1;
         case (field_ff)
            F_STAMP: begin
               if (pos_ff < TS_FRACTION) begin
                  if (c < ts_lo(pos_ff[4:0]) || c > ts_hi(pos_ff[4:0])) go = GO_BAD;
                  else pos_in = pos_ff + 6'd1;
               end else if (pos_ff == TS_FRACTION) begin
                  if (item.digit && run_ff < FRAC_DIGITS_MAX) run_in = run_ff + 8'd1;
                  else if (run_ff == '0) go = GO_BAD;
                  else if (c == "Z") pos_in = TS_TAB;
                  else if (c == "+" || c == "-") pos_in = TS_ZONE;
                  else go = GO_BAD;
               end else if (pos_ff == TS_COLON) begin
                  if (c != ":") go = GO_BAD;
                  else pos_in = pos_ff + 6'd1;
               end else if (pos_ff >= TS_ZONE && pos_ff < TS_TAB) begin
                  if (!item.digit) go = GO_BAD;
                  else pos_in = pos_ff + 6'd1;
               end else if (pos_ff == TS_TAB) begin
                  go = item.tab ? GO_NEXT : GO_BAD;
               end else begin
                  go = GO_BAD;
               end
            end
            F_SEQ, F_CODE: begin
               if (item.digit) begin
                  if (run_ff >= NUM_DIGITS_MAX) begin
                     go = GO_BAD;
                  end else begin
                     run_in = run_ff + 8'd1;
                     if (!ovf_ff) begin
                        // overflow past 2^63-1 when value*10+d would exceed it
                        if (num_ff > SEQ_LIMIT || (num_ff == SEQ_LIMIT && item.digit_val > 4'd7))
                           ovf_in = 1'b1;
                        else
                           num_in = num_x10;
                     end
                  end
               end else if (item.tab) begin
                  go = ovf_ff ? GO_BAD : GO_NEXT;
               end else begin
                  go = GO_BAD;
               end
            end
            F_NAME: begin
               if (pos_ff == '0) begin
                  if (!(item.lower || item.upper)) go = GO_BAD;
                  else pos_in = 6'd1;
               end else if (item.tab) begin
                  go = (pos_ff <= name_max_ff) ? GO_NEXT : GO_BAD;
               end else if ((item.lower || item.upper || item.digit || c == "_")
                            && pos_ff < name_max_ff) begin
                  pos_in = pos_ff + 6'd1;
               end else begin
                  go = GO_BAD;
               end
            end
            F_CLASS: begin
               if (pos_ff == '0) begin
                  pos_in = 6'd1;
                  case (c)
                     "E":     run_in = 8'd0;
                     "N":     run_in = 8'd1;
                     "O":     run_in = 8'd2;
                     "S":     run_in = 8'd3;
                     default: go = GO_BAD;
                  endcase
               end else if (pos_ff < class_len(k)) begin
                  if (class_char(k, pos_ff) != c) go = GO_BAD;
                  else pos_in = pos_ff + 6'd1;
               end else if (pos_ff == class_len(k) && item.tab) begin
                  go = GO_NEXT;
               end else begin
                  go = GO_BAD;
               end
            end
            F_DIGEST: begin
               if (pos_ff == DIGEST_PART) begin
                  if (item.graph && run_ff < digest_max_ff) run_in = run_ff + 8'd1;
                  else go = item.tab ? GO_NEXT : GO_BAD;
               end else if (pos_ff == '0) begin
                  if (!item.lower) go = GO_BAD;
                  else pos_in = 6'd1;
               end else if (c == ":" && pos_ff <= {2'b00, algo_max_ff}) begin
                  pos_in = DIGEST_PART;
               end else if ((item.lower || item.digit) && pos_ff < {2'b00, algo_max_ff}) begin
                  pos_in = pos_ff + 6'd1;
               end else begin
                  go = GO_BAD;
               end
            end
            F_DUR0, F_DUR1, F_DUR2: begin
               if (pos_ff == '0) begin
                  if (item.digit) begin
                     if (run_ff >= SEC_DIGITS_MAX) begin
                        go = GO_BAD;
                     end else begin
                        run_in = run_ff + 8'd1;
                        num_in = num_x10;
                     end
                  end else if (c != "." || num_ff > SEC_MAX) begin
                     go = GO_BAD;
                  end else begin
                     pos_in = 6'd1;
                     run_in = '0;
                  end
               end else if (item.digit && run_ff < FRAC_DIGITS_MAX) begin
                  run_in = run_ff + 8'd1;
               end else if (run_ff == '0) begin
                  go = GO_BAD;
               end else if (field_ff == F_DUR2) begin
                  go = item.nl ? GO_LINE : GO_BAD;
               end else begin
                  go = item.tab ? GO_NEXT : GO_BAD;
               end
            end
            default: go = GO_BAD;
         endcase

         case (go)
            GO_BAD: begin
               rej_in  = 1'b1;
               verd_in = V_REJECT;
               field_in = field_ff;
               pos_in  = pos_ff;
               run_in  = run_ff;
               num_in  = num_ff;
               ovf_in  = ovf_ff;
            end
            GO_NEXT, GO_LINE: begin
               pos_in   = '0;
               run_in   = '0;
               num_in   = '0;
               ovf_in   = 1'b0;
               field_in = (go == GO_LINE) ? F_STAMP : field_ff + 4'd1;
               verd_in  = (go == GO_LINE) ? V_RECORD : V_PENDING;
            end
            default: verd_in = V_PENDING;
         endcase
      end

      if (item_pop) oval_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_max_ff   <= 6'd63;
         algo_max_ff   <= 4'd8;
         digest_max_ff <= 8'd128;
         field_ff      <= F_STAMP;
         pos_ff        <= '0;
         run_ff        <= '0;
         num_ff        <= '0;
         ovf_ff        <= 1'b0;
         seen_ff       <= 1'b0;
         rej_ff        <= 1'b0;
         oval_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_NAME_MAX:   name_max_ff   <= csr_data[5:0];
               CSR_ALGO_MAX:   algo_max_ff   <= csr_data[3:0];
               CSR_DIGEST_MAX: digest_max_ff <= csr_data;
               default: ;
            endcase
         end
         oval_ff <= oval_in;
         if (item_pop) begin
            field_ff <= field_in;
            pos_ff   <= pos_in;
            run_ff   <= run_in;
            num_ff   <= num_in;
            ovf_ff   <= ovf_in;
            seen_ff  <= seen_in;
            rej_ff   <= rej_in;
         end
      end
      if (item_pop) begin
         verd_ff <= verd_in;
         ofld_ff <= ofld_in;
      end
   end

endmodule

### bench/tb_exec_record_log_validator_core.sv
module tb_exec_record_log_validator_core;
   import erlv_pkg::*;

   logic clock;
   logic reset;

   erlv_req_if req_ch ();
   erlv_rsp_if rsp_ch ();
   erlv_csr_if csr_ch ();

   exec_record_log_validator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // expected result of one byte transfer
   typedef struct {
      logic [2:0] verdict;
      logic [3:0] field_number;
   } result_type;

   // one directed row: byte, end flag, and optionally a typed-in verdict
   typedef struct {
      logic [7:0] data_byte;
      logic       stream_end;
      logic       has_fixed;
      logic [2:0] fixed_verdict;
      logic [3:0] fixed_field;
   } row_type;

   result_type verdict_q[$];
   int         mismatches;
   int         idle_cycles;
   bit         timed_out;
   bit         calm;          // stretch with no idling on either side

   // scanner copy of the block
   logic [5:0]  lim_name;
   logic [3:0]  lim_algo;
   logic [7:0]  lim_digest;
   logic [3:0]  s_field;
   logic [5:0]  s_pos;
   logic [7:0]  s_run;
   logic [63:0] s_num;
   logic        s_ovf;
   logic        s_seen;
   logic        s_rej;

   // stimulus byte queues
   logic [7:0]  send_byte_q[$];
   logic        send_end_q[$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_low(logic [7:0] c);
      return c >= "a" && c <= "z";
   endfunction

   function automatic bit is_alp(logic [7:0] c);
      return is_low(c) || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [7:0] stamp_lo(int p);
      string s;
      s = "2000-00-00T00:00:00.";
      return s[p];
   endfunction

   function automatic logic [7:0] stamp_hi(int p);
      string s;
      s = "5999-19-39T29:59:59.";
      return s[p];
   endfunction

   function automatic string class_word(int k);
      case (k)
         0: return "ERR";
         1: return "NOPS";
         2: return "OK";
         default: return "SIG";
      endcase
   endfunction

   task automatic clear_field();
      s_pos = '0;
      s_run = '0;
      s_num = '0;
      s_ovf = 1'b0;
   endtask

   task automatic scan_stamp(input logic [7:0] c, output step_type r);
      int p;
      p = s_pos;
      r = GO_ON;
      if (p < TS_FRACTION) begin
         if (c < stamp_lo(p) || c > stamp_hi(p)) r = GO_BAD;
         else s_pos = 6'(p + 1);
      end else if (p == TS_FRACTION) begin
         if (is_dig(c) && s_run < FRAC_DIGITS_MAX) s_run++;
         else if (s_run == 0) r = GO_BAD;
         else if (c == "Z") s_pos = TS_TAB;
         else if (c == "+" || c == "-") s_pos = TS_ZONE;
         else r = GO_BAD;
      end else if (p == TS_COLON) begin
         if (c != ":") r = GO_BAD;
         else s_pos = 6'(p + 1);
      end else if (p >= TS_ZONE && p < TS_TAB) begin
         if (!is_dig(c)) r = GO_BAD;
         else s_pos = 6'(p + 1);
      end else if (p == TS_TAB) begin
         r = (c == TAB_CHAR) ? GO_NEXT : GO_BAD;
      end else begin
         r = GO_BAD;
      end
   endtask

   task automatic scan_number(input logic [7:0] c, output step_type r);
      logic [63:0] d;
      r = GO_ON;
      if (is_dig(c)) begin
         d = c - "0";
         if (s_run >= NUM_DIGITS_MAX) r = GO_BAD;
         else begin
            s_run++;
            if (!s_ovf) begin
               if (s_num > (64'd9223372036854775807 - d) / 10) s_ovf = 1'b1;
               else s_num = s_num * 10 + d;
            end
         end
      end else if (c == TAB_CHAR) r = s_ovf ? GO_BAD : GO_NEXT;
      else r = GO_BAD;
   endtask

   task automatic scan_label(input logic [7:0] c, output step_type r);
      r = GO_ON;
      if (s_pos == 0) begin
         if (!is_alp(c)) r = GO_BAD;
         else s_pos = 1;
      end else if (c == TAB_CHAR) r = (s_pos <= lim_name) ? GO_NEXT : GO_BAD;
      else if ((is_alp(c) || is_dig(c) || c == "_") && s_pos < lim_name) s_pos++;
      else r = GO_BAD;
   endtask

   task automatic scan_class(input logic [7:0] c, output step_type r);
      string w;
      int    k;
      r = GO_BAD;
      if (s_pos == 0) begin
         for (k = 0; k < 4; k++) begin
            w = class_word(k);
            if (r == GO_BAD && w[0] == c) begin
               s_run = 8'(k);
               s_pos = 1;
               r = GO_ON;
            end
         end
      end else begin
         w = class_word(s_run[1:0]);
         if (s_pos < w.len()) begin
            if (w[s_pos] == c) begin
               s_pos++;
               r = GO_ON;
            end
         end else if (s_pos == w.len() && c == TAB_CHAR) r = GO_NEXT;
      end
   endtask

   task automatic scan_digest(input logic [7:0] c, output step_type r);
      r = GO_ON;
      if (s_pos == DIGEST_PART) begin
         if (c >= 8'h21 && c <= 8'h7e && s_run < lim_digest) s_run++;
         else r = (c == TAB_CHAR) ? GO_NEXT : GO_BAD;
      end else if (s_pos == 0) begin
         if (!is_low(c)) r = GO_BAD;
         else s_pos = 1;
      end else if (c == ":" && s_pos <= lim_algo) s_pos = DIGEST_PART;
      else if ((is_low(c) || is_dig(c)) && s_pos < lim_algo) s_pos++;
      else r = GO_BAD;
   endtask

   task automatic scan_span(input logic [7:0] c, input bit last, output step_type r);
      r = GO_ON;
      if (s_pos == 0) begin
         if (is_dig(c)) begin
            if (s_run >= SEC_DIGITS_MAX) r = GO_BAD;
            else begin
               s_run++;
               s_num = s_num * 10 + (c - "0");
            end
         end else if (c != "." || s_num > SEC_MAX) r = GO_BAD;
         else begin
            s_pos = 1;
            s_run = 0;
         end
      end else if (is_dig(c) && s_run < FRAC_DIGITS_MAX) s_run++;
      else if (s_run == 0) r = GO_BAD;
      else if (last) r = (c == NL_CHAR) ? GO_LINE : GO_BAD;
      else r = (c == TAB_CHAR) ? GO_NEXT : GO_BAD;
   endtask

   task automatic clear_stream();
      clear_field();
      s_field = '0;
      s_seen = 1'b0;
      s_rej = 1'b0;
   endtask

   // advances the scanner copy by one transfer and returns its verdict
   task automatic predict_verdict(input logic [7:0] c, input logic fin,
                                  output result_type v);
      step_type r;
      v.field_number = s_field;
      if (fin) begin
         if (!s_seen) begin
            v.verdict = V_EMPTY;
            v.field_number = '0;
         end else if (s_rej || s_field != 0 || s_pos != 0) v.verdict = V_REJECT;
         else begin
            v.verdict = V_VALID;
            v.field_number = '0;
         end
         clear_stream();
      end else if (s_rej || c == 0) begin
         v.verdict = s_rej ? V_REJECT : V_PENDING;
      end else begin
         s_seen = 1'b1;
         case (s_field)
            F_STAMP:          scan_stamp(c, r);
            F_SEQ, F_CODE:    scan_number(c, r);
            F_NAME:           scan_label(c, r);
            F_CLASS:          scan_class(c, r);
            F_DIGEST:         scan_digest(c, r);
            F_DUR0, F_DUR1, F_DUR2: scan_span(c, s_field == F_DUR2, r);
            default:          r = GO_BAD;
         endcase
         v.verdict = V_PENDING;
         case (r)
            GO_BAD: begin
               s_rej = 1'b1;
               v.verdict = V_REJECT;
            end
            GO_NEXT: begin
               clear_field();
               s_field = s_field + 4'd1;
            end
            GO_LINE: begin
               clear_field();
               s_field = '0;
               v.verdict = V_RECORD;
            end
            default: ;
         endcase
      end
   endtask

   // --- record text builders for the random part
   function automatic string rand_digits(int lo, int hi);
      string s;
      int    n;
      s = "";
      n = $urandom_range(hi, lo);
      for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
      return s;
   endfunction

   function automatic string rand_chars(int n, int kind);
      string s;
      logic [7:0] c;
      s = "";
      for (int i = 0; i < n; i++) begin
         case (kind)
            0: c = 8'("a" + $urandom_range(25));
            1: c = ($urandom_range(3) == 0) ? "_" : 8'("A" + $urandom_range(25));
            default: c = 8'($urandom_range(8'h7e, 8'h21));
         endcase
         s = {s, string'(c)};
      end
      return s;
   endfunction

   function automatic string rand_record();
      string s;
      int    t;
      s = {string'(8'("2" + $urandom_range(3))), rand_digits(3, 3), "-",
           string'(8'("0" + $urandom_range(1))), rand_digits(1, 1), "-",
           string'(8'("0" + $urandom_range(3))), rand_digits(1, 1), "T",
           string'(8'("0" + $urandom_range(2))), rand_digits(1, 1), ":",
           string'(8'("0" + $urandom_range(5))), rand_digits(1, 1), ":",
           string'(8'("0" + $urandom_range(5))), rand_digits(1, 1), ".",
           rand_digits(1, 9)};
      t = $urandom_range(2);
      if (t == 0) s = {s, "Z"};
      else s = {s, (t == 1) ? "+" : "-", rand_digits(2, 2), ":", rand_digits(2, 2)};
      s = {s, "\t", rand_digits(0, ($urandom_range(7) == 0) ? 21 : 6), "\t"};
      s = {s, rand_chars(1, 1), rand_chars($urandom_range(lim_name), 1), "\t"};
      s = {s, class_word($urandom_range(3)), "\t"};
      s = {s, rand_chars(1, 0), rand_chars($urandom_range(lim_algo), 0), ":",
           rand_chars($urandom_range(lim_digest > 6 ? 6 : lim_digest), 2), "\t"};
      s = {s, rand_digits(0, 4), "\t"};
      for (int d = 0; d < 3; d++)
         s = {s, rand_digits(0, ($urandom_range(5) == 0) ? 10 : 3), ".",
              rand_digits(1, 9), (d == 2) ? "\n" : "\t"};
      return s;
   endfunction

   // queue a record, maybe broken or sprinkled with stray bytes
   task automatic push_record();
      string s;
      int    i;
      logic [7:0] c;
      s = rand_record();
      if ($urandom_range(4) == 0) begin
         i = $urandom_range(s.len() - 1);
         c = 8'($urandom);
         s[i] = (c == 0) ? 8'hff : c;
      end
      for (i = 0; i < s.len(); i++) begin
         if ($urandom_range(40) == 0) begin
            send_byte_q.push_back(8'h00);
            send_end_q.push_back(1'b0);
         end
         send_byte_q.push_back(s[i]);
         send_end_q.push_back(1'b0);
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic fin);
      send_byte_q.push_back(b);
      send_end_q.push_back(fin);
   endtask

   // --- response side: random stalls and field-by-field checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 8);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdict_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer: verdict %0d field %0d",
                           rsp_ch.verdict, rsp_ch.field_number);
            end else begin
               result_type want;
               want = verdict_q.pop_front();
               if (rsp_ch.verdict !== want.verdict ||
                   rsp_ch.field_number !== want.field_number) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("verdict mismatch: want %0d/%0d got %0d/%0d",
                              want.verdict, want.field_number,
                              rsp_ch.verdict, rsp_ch.field_number);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000 && !timed_out) begin
         timed_out = 1'b1;
         $display("exec_record_log_validator_core: mismatch");
         $finish;
      end
   end

   // drain the send queue through the request channel, predicting per transfer
   task automatic send_all();
      result_type v;
      while (send_byte_q.size() > 0) begin
         if (calm || $urandom_range(99) >= 8) begin
            req_ch.valid      <= 1'b1;
            req_ch.data_byte  <= send_byte_q[0];
            req_ch.stream_end <= send_end_q[0];
            @(posedge clock);
            while (!req_ch.ready) @(posedge clock);
            predict_verdict(send_byte_q[0], send_end_q[0], v);
            verdict_q.push_back(v);
            void'(send_byte_q.pop_front());
            void'(send_end_q.pop_front());
         end else begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (verdict_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_NAME_MAX:   lim_name = val[5:0];
         CSR_ALGO_MAX:   lim_algo = val[3:0];
         CSR_DIGEST_MAX: lim_digest = val;
         default: ;
      endcase
   endtask

   // directed table
   row_type table_rows[$];

   task automatic add_row(input logic [7:0] b, input logic fin, input bit fixed,
                          input logic [2:0] vd, input logic [3:0] fn);
      row_type r;
      r.data_byte = b;
      r.stream_end = fin;
      r.has_fixed = fixed;
      r.fixed_verdict = vd;
      r.fixed_field = fn;
      table_rows.push_back(r);
   endtask

   initial begin
      result_type v;
      string      rec;
      calm = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.stream_end = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      lim_name = 6'd63;
      lim_algo = 4'd8;
      lim_digest = 8'd128;
      clear_stream();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: empty stream, nul only, a rejected stream, one good record with extremes
      add_row(8'h00, 1'b1, 1'b1, V_EMPTY, F_STAMP);
      add_row(8'h00, 1'b0, 1'b1, V_PENDING, F_STAMP);
      add_row(8'hff, 1'b1, 1'b1, V_EMPTY, F_STAMP);
      add_row("6", 1'b0, 1'b1, V_REJECT, F_STAMP);
      add_row("2", 1'b0, 1'b1, V_REJECT, F_STAMP);
      add_row(8'h00, 1'b1, 1'b1, V_REJECT, F_STAMP);
      rec = "5999-19-39T29:59:59.123456789-23:59\t9223372036854775807\tZ_9\tNOPS\tz9:~!\t\t";
      rec = {rec, "2147483647.1\t0.999999999\t.5\n"};
      for (int i = 0; i < rec.len(); i++) add_row(rec[i], 1'b0, 1'b0, V_PENDING, F_STAMP);
      add_row(8'h00, 1'b1, 1'b1, V_VALID, F_STAMP);
      foreach (table_rows[i]) begin
         predict_verdict(table_rows[i].data_byte, table_rows[i].stream_end, v);
         if (table_rows[i].has_fixed) begin
            v.verdict = table_rows[i].fixed_verdict;
            v.field_number = table_rows[i].fixed_field;
         end
         req_ch.valid      <= 1'b1;
         req_ch.data_byte  <= table_rows[i].data_byte;
         req_ch.stream_end <= table_rows[i].stream_end;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         verdict_q.push_back(v);
      end
      req_ch.valid <= 1'b0;
      wait_drain();

      // random part over several limit settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_NAME_MAX, 8'd1);
               write_csr(CSR_ALGO_MAX, 8'd1);
               write_csr(CSR_DIGEST_MAX, 8'd0);
            end
            1: begin
               write_csr(CSR_NAME_MAX, 8'd0);
               write_csr(CSR_ALGO_MAX, 8'd0);
               write_csr(CSR_DIGEST_MAX, 8'd255);
            end
            2: begin
               write_csr(CSR_NAME_MAX, 8'd63);
               write_csr(CSR_ALGO_MAX, 8'd15);
               write_csr(CSR_DIGEST_MAX, 8'd128);
            end
            default: begin
               write_csr(CSR_NAME_MAX, 8'($urandom_range(63)));
               write_csr(CSR_ALGO_MAX, 8'($urandom_range(15)));
               write_csr(CSR_DIGEST_MAX, 8'($urandom));
            end
         endcase
         calm = (phase == 3);
         for (int n = 0; n < 1; n++) begin
            push_record();
            if ($urandom_range(3) == 0)
               for (int k = 0; k < 6; k++) push_byte(8'($urandom), 1'b0);
            if ($urandom_range(2) == 0) push_byte(8'($urandom), 1'b1);
         end
         push_byte(8'($urandom), 1'b1);
         send_all();
         wait_drain();
      end
      calm = 1'b0;

      if (mismatches == 0)
         $display("exec_record_log_validator_core: match");
      else
         $display("exec_record_log_validator_core: mismatch");
      $finish;
   end

endmodule
